// ===== design/cfe_pkg.sv =====
// Shared definitions for the CRC-32 frame engine: mode codes, CRC constants
// and the byte-wide reflected CRC update function.
// No dependencies.
`timescale 1ns / 1ps

package cfe_pkg;

  typedef logic [1:0] mode_t;

  // Mode codes; the unused code behaves as compute.
  localparam mode_t MODE_COMPUTE = 2'd0;
  localparam mode_t MODE_APPEND  = 2'd1;
  localparam mode_t MODE_VERIFY  = 2'd2;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  // Number of CRC bytes sent after a frame in append mode.
  localparam int unsigned TRAILER_BYTES = 4;

  // Advance a reflected CRC-32 register by one byte (eight shift steps).
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = {24'd0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c ^ (crc >> 8);
  endfunction

endpackage

// ===== design/crc32_frame_engine_top.sv =====
// CRC-32 frame engine: one input byte per word, CRC compute, append and verify modes.
// Depends on cfe_pkg.
`timescale 1ns / 1ps

// The engine takes one frame byte per input word, with frame_last on the final
// byte, and keeps a reflected CRC-32 (polynomial 0xEDB88320, init and final XOR
// all ones). Mode (cfg_data, written with cfg_we while idle) selects compute (one
// result word carrying the CRC at frame end), append (every byte is passed
// through, then four CRC bytes follow, most significant first) or verify (the
// last four bytes are taken as a big-endian CRC and one result word reports the
// match; frames under four bytes fail). Throughput is one byte per clock while
// the output is not stalled and no trailer drains: the byte-wide CRC update sits
// between the input register and the result register. In append mode the input
// stalls at a frame end while the four CRC trailer bytes drain from the result register.
module crc32_frame_engine_top
  import cfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        frame_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [31:0] crc_value,
  output logic        verify_ok,
  output logic        run_last
);

  // Mode register.
  mode_t mode;

  // Input register stage.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // Frame state.
  logic [31:0] crc_reg;
  logic [7:0]  win [4];
  logic [2:0]  bytes_seen;

  // Append trailer: CRC held and count of bytes still to send.
  logic [31:0] pend_crc;
  logic [2:0]  pend_cnt;

  // Next values and the result formed from the word in the input register.
  logic [31:0] crc_next;
  logic [7:0]  win_next [4];
  logic [2:0]  bytes_seen_next;
  logic [31:0] final_crc;
  logic [31:0] trail_crc;
  logic        res_has;
  logic [7:0]  res_byte;
  logic [31:0] res_crc;
  logic        res_ok;
  logic        res_last;
  logic        pend_load;
  logic [7:0]  trailer_byte;

  logic out_free;
  logic s1_go;

  assign out_free = !out_valid || out_ready;
  assign s1_go    = s1_valid && (pend_cnt == 3'd0) && out_free;
  assign in_ready = !s1_valid || s1_go;

  // Mode register write.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_COMPUTE;
    end else if (cfg_we) begin
      mode <= cfg_data;
    end
  end

  // Input register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= in_byte;
      s1_last <= frame_last;
    end
  end

  // Per-byte processing for the three modes.
  always_comb begin
    crc_next        = crc_reg;
    win_next        = win;
    bytes_seen_next = bytes_seen;
    final_crc       = 32'd0;
    trail_crc       = 32'd0;
    res_has         = 1'b0;
    res_byte        = 8'd0;
    res_crc         = 32'd0;
    res_ok          = 1'b0;
    res_last        = 1'b1;
    pend_load       = 1'b0;
    unique case (mode)
      MODE_APPEND: begin
        crc_next  = crc32_byte(crc_reg, s1_byte);
        final_crc = crc_next ^ CRC_ONES;
        res_has   = 1'b1;
        res_byte  = s1_byte;
        res_last  = !s1_last;
        pend_load = s1_last;
      end
      MODE_VERIFY: begin
        if (bytes_seen == 3'd4) begin
          // Oldest held byte leaves the window and enters the CRC.
          crc_next    = crc32_byte(crc_reg, win[0]);
          win_next[0] = win[1];
          win_next[1] = win[2];
          win_next[2] = win[3];
          win_next[3] = s1_byte;
        end else begin
          win_next[bytes_seen[1:0]] = s1_byte;
          bytes_seen_next           = bytes_seen + 3'd1;
        end
        final_crc = crc_next ^ CRC_ONES;
        trail_crc = {win_next[0], win_next[1], win_next[2], win_next[3]};
        res_has   = s1_last;
        if (bytes_seen_next == 3'd4) begin
          res_crc = final_crc;
          res_ok  = (final_crc == trail_crc);
        end
      end
      default: begin
        crc_next  = crc32_byte(crc_reg, s1_byte);
        final_crc = crc_next ^ CRC_ONES;
        res_has   = s1_last;
        res_crc   = final_crc;
      end
    endcase
  end

  // Frame state update; a frame end returns the CRC and count to reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg    <= CRC_ONES;
      bytes_seen <= 3'd0;
    end else if (s1_go) begin
      if (s1_last) begin
        crc_reg    <= CRC_ONES;
        bytes_seen <= 3'd0;
      end else begin
        crc_reg    <= crc_next;
        bytes_seen <= bytes_seen_next;
      end
    end
  end

  // Window contents are only read once all four entries have been written.
  always_ff @(posedge clk) begin
    if (s1_go) begin
      win <= win_next;
    end
  end

  // Trailer byte selection, most significant byte first.
  always_comb begin
    unique case (pend_cnt)
      3'd4:    trailer_byte = pend_crc[31:24];
      3'd3:    trailer_byte = pend_crc[23:16];
      3'd2:    trailer_byte = pend_crc[15:8];
      default: trailer_byte = pend_crc[7:0];
    endcase
  end

  // Result register control and trailer counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_cnt  <= 3'd0;
    end else if (s1_go && res_has) begin
      out_valid <= 1'b1;
      if (pend_load) begin
        pend_cnt <= 3'(TRAILER_BYTES);
      end
    end else if (pend_cnt != 3'd0 && out_free) begin
      out_valid <= 1'b1;
      pend_cnt  <= pend_cnt - 3'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (s1_go && res_has) begin
      out_byte  <= res_byte;
      crc_value <= res_crc;
      verify_ok <= res_ok;
      run_last  <= res_last;
      if (pend_load) begin
        pend_crc <= final_crc;
      end
    end else if (pend_cnt != 3'd0 && out_free) begin
      out_byte  <= trailer_byte;
      crc_value <= pend_crc;
      verify_ok <= 1'b0;
      run_last  <= (pend_cnt == 3'd1);
    end
  end

  // The input register never advances while a trailer is draining.
  a_no_advance_in_trailer: assert property (@(posedge clk) disable iff (rst)
    (pend_cnt != 3'd0) |-> !s1_go)
    else $error("input word processed during CRC trailer");

  // Counters stay in range.
  a_counts_in_range: assert property (@(posedge clk) disable iff (rst)
    (pend_cnt <= 3'd4) && (bytes_seen <= 3'd4))
    else $error("trailer or byte count out of range");

  // A frame end leaves the CRC and byte count at their reset values.
  a_frame_end_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last) |=> (crc_reg == CRC_ONES) && (bytes_seen == 3'd0))
    else $error("frame state not cleared after frame end");

  // A taken result with nothing to follow empties the result register.
  a_out_drains: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && pend_cnt == 3'd0 && !s1_go) |=> !out_valid)
    else $error("result register holds a word already taken");

  // The final trailer byte carries run_last.
  a_trailer_last: assert property (@(posedge clk) disable iff (rst)
    (pend_cnt == 3'd1 && out_free) |=> out_valid && run_last)
    else $error("last trailer byte without run_last");

endmodule
